>>> hdl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg: ARP cache shared types and microcode
// Field widths, entry layout, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int NUM_ENTRIES_DEF = 64;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int TIME_W          = 32;
    localparam int LIFE_W          = 12;
    localparam int OP_W            = 2;
    localparam int APB_DW          = 32;
    localparam int APB_AW          = 3;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 12'd15;
    localparam logic [0:0]        REG_LIFETIME   = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef struct packed {
        logic              valid;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] added;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        CTR_HOLD,
        CTR_CLEAR,
        CTR_INC
    } t_ctr_op;

    typedef enum logic [1:0] {
        RAM_IDLE,
        RAM_CLEAR,
        RAM_SCAN
    } t_ram_op;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_LOOK,
        DP_INSERT,
        DP_TICK_INC,
        DP_TICK,
        DP_RESULT
    } t_dp_op;

    typedef enum logic [2:0] {
        C_GOTO,
        C_NO_START,
        C_CLR_BUSY,
        C_SCAN_BUSY,
        C_INS_BUSY,
        C_OP_LOOKUP,
        C_OP_INSERT,
        C_OP_TICK
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step ST_CLEAR     = 4'd0;
    localparam t_step ST_IDLE      = 4'd1;
    localparam t_step ST_DISP_LOOK = 4'd2;
    localparam t_step ST_DISP_INS  = 4'd3;
    localparam t_step ST_DISP_TICK = 4'd4;
    localparam t_step ST_NOP       = 4'd5;
    localparam t_step ST_LOOK      = 4'd6;
    localparam t_step ST_LOOK_END  = 4'd7;
    localparam t_step ST_INS       = 4'd8;
    localparam t_step ST_INS_END   = 4'd9;
    localparam t_step ST_TICK_INC  = 4'd10;
    localparam t_step ST_TICK      = 4'd11;
    localparam t_step ST_RESULT    = 4'd12;

    typedef struct packed {
        logic    idle;
        t_ctr_op ctr_op;
        t_ram_op ram_op;
        t_dp_op  dp_op;
        t_cond   cond;
        t_step   target;
    } t_uword;

    typedef struct packed {
        logic    idle;
        t_ctr_op ctr_op;
        t_ram_op ram_op;
        t_dp_op  dp_op;
    } t_ctrl;

    typedef struct packed {
        logic clr_last;
        logic scan_done;
        logic ins_found;
        logic op_lookup;
        logic op_insert;
        logic op_tick;
    } t_stat;

    // taken condition jumps to target, otherwise fall through to the next step
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            ST_CLEAR:     w = t_uword'{1'b0, CTR_INC,   RAM_CLEAR, DP_NONE,     C_CLR_BUSY,
                                       ST_CLEAR};
            ST_IDLE:      w = t_uword'{1'b1, CTR_CLEAR, RAM_IDLE,  DP_ACCEPT,   C_NO_START,
                                       ST_IDLE};
            ST_DISP_LOOK: w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_OP_LOOKUP,
                                       ST_LOOK};
            ST_DISP_INS:  w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_OP_INSERT,
                                       ST_INS};
            ST_DISP_TICK: w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_OP_TICK,
                                       ST_TICK_INC};
            ST_NOP:       w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_GOTO,
                                       ST_RESULT};
            ST_LOOK:      w = t_uword'{1'b0, CTR_INC,   RAM_SCAN,  DP_LOOK,     C_SCAN_BUSY,
                                       ST_LOOK};
            ST_LOOK_END:  w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_GOTO,
                                       ST_RESULT};
            ST_INS:       w = t_uword'{1'b0, CTR_INC,   RAM_SCAN,  DP_INSERT,   C_INS_BUSY,
                                       ST_INS};
            ST_INS_END:   w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_GOTO,
                                       ST_RESULT};
            ST_TICK_INC:  w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_TICK_INC, C_GOTO,
                                       ST_TICK};
            ST_TICK:      w = t_uword'{1'b0, CTR_INC,   RAM_SCAN,  DP_TICK,     C_SCAN_BUSY,
                                       ST_TICK};
            ST_RESULT:    w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_RESULT,   C_GOTO,
                                       ST_IDLE};
            default:      w = t_uword'{1'b0, CTR_HOLD,  RAM_IDLE,  DP_NONE,     C_GOTO,
                                       ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/arpc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/arpc_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_sequencer: microcode step counter
// Fetches one control word a step and resolves conditional jumps.
// ----------------------------------------------------------------------------
module arpc_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  arpc_pkg::t_stat i_stat,
    output arpc_pkg::t_ctrl o_ctrl
);

    arpc_pkg::t_step  r_step;
    arpc_pkg::t_step  n_step;
    arpc_pkg::t_uword w_uword;
    logic             w_take;

    assign w_uword = arpc_pkg::ucode(r_step);

    always_comb begin
        unique case (w_uword.cond)
            arpc_pkg::C_GOTO:      w_take = 1'b1;
            arpc_pkg::C_NO_START:  w_take = !i_start;
            arpc_pkg::C_CLR_BUSY:  w_take = !i_stat.clr_last;
            arpc_pkg::C_SCAN_BUSY: w_take = !i_stat.scan_done;
            arpc_pkg::C_INS_BUSY:  w_take = !(i_stat.ins_found || i_stat.scan_done);
            arpc_pkg::C_OP_LOOKUP: w_take = i_stat.op_lookup;
            arpc_pkg::C_OP_INSERT: w_take = i_stat.op_insert;
            arpc_pkg::C_OP_TICK:   w_take = i_stat.op_tick;
            default:               w_take = 1'b1;
        endcase
    end

    always_comb begin
        n_step = w_take ? w_uword.target : r_step + 4'd1;
    end

    always_comb begin
        o_ctrl.idle   = w_uword.idle;
        o_ctrl.ctr_op = w_uword.ctr_op;
        o_ctrl.ram_op = w_uword.ram_op;
        o_ctrl.dp_op  = w_uword.dp_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= arpc_pkg::ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> hdl/arpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_datapath: ARP cache table datapath
// Entry RAM, scan counter, read pipeline, seconds counter and result flags.
// ----------------------------------------------------------------------------
module arpc_datapath #(
    parameter int NUM_ENTRIES = arpc_pkg::NUM_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  arpc_pkg::t_ctrl             i_ctrl,
    input  logic                        i_start,
    input  logic [arpc_pkg::OP_W-1:0]   i_operation,
    input  logic [arpc_pkg::IP_W-1:0]   i_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]  i_mac_address,
    input  logic [arpc_pkg::LIFE_W-1:0] i_lifetime,
    output arpc_pkg::t_stat             o_stat,
    output logic                        o_done,
    output logic                        o_hit,
    output logic [arpc_pkg::MAC_W-1:0]  o_found_mac,
    output logic                        o_stored
);

    localparam int AW   = $clog2(NUM_ENTRIES);
    localparam int CW   = $clog2(NUM_ENTRIES + 1);
    localparam int LAST = NUM_ENTRIES - 1;

    logic [CW-1:0]                 r_ctr;
    logic                          r_rd_vld;
    logic [AW-1:0]                 r_rd_idx;
    arpc_pkg::t_op                 r_op;
    logic [arpc_pkg::IP_W-1:0]     r_ip;
    logic [arpc_pkg::MAC_W-1:0]    r_mac;
    logic [arpc_pkg::TIME_W-1:0]   r_secs;
    logic                          r_hit;
    logic [arpc_pkg::MAC_W-1:0]    r_fmac;
    logic                          r_stored;
    logic                          r_done;

    arpc_pkg::t_entry              w_rd;
    arpc_pkg::t_entry              w_wdata;
    logic [arpc_pkg::ENTRY_W-1:0]  w_rdata;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic                          w_issue;
    logic                          w_below;
    logic                          w_accept;
    logic                          w_ins_found;
    logic                          w_ins_wr;
    logic                          w_expire;
    logic                          w_tick_wr;
    logic                          w_match;
    logic [arpc_pkg::TIME_W-1:0]   w_age;

    assign w_rd        = arpc_pkg::t_entry'(w_rdata);
    assign w_below     = r_ctr < CW'(NUM_ENTRIES);
    assign w_issue     = (i_ctrl.ram_op == arpc_pkg::RAM_SCAN) && w_below;
    assign w_accept    = (i_ctrl.dp_op == arpc_pkg::DP_ACCEPT) && i_start;
    assign w_ins_found = r_rd_vld && !w_rd.valid;
    assign w_ins_wr    = (i_ctrl.dp_op == arpc_pkg::DP_INSERT) && w_ins_found;
    assign w_age       = r_secs - w_rd.added;
    assign w_expire    = w_rd.valid && (w_age > arpc_pkg::TIME_W'(i_lifetime));
    assign w_tick_wr   = (i_ctrl.dp_op == arpc_pkg::DP_TICK) && r_rd_vld && w_expire;
    assign w_match     = (i_ctrl.dp_op == arpc_pkg::DP_LOOK) && r_rd_vld && w_rd.valid
                         && (w_rd.ip == r_ip);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_idx;
        w_wdata = w_rd;
        if (i_ctrl.ram_op == arpc_pkg::RAM_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_ctr[AW-1:0];
            w_wdata = '0;
        end else if (w_ins_wr) begin
            w_we    = 1'b1;
            w_wdata = arpc_pkg::t_entry'{1'b1, r_ip, r_mac, r_secs};
        end else if (w_tick_wr) begin
            w_we          = 1'b1;
            w_wdata.valid = 1'b0;
        end
    end

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (NUM_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_ctr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr    <= '0;
            r_rd_vld <= 1'b0;
            r_secs   <= '0;
            r_done   <= 1'b0;
        end else begin
            case (i_ctrl.ctr_op)
                arpc_pkg::CTR_CLEAR: r_ctr <= '0;
                arpc_pkg::CTR_INC:   r_ctr <= w_below ? r_ctr + CW'(1) : r_ctr;
                default:             r_ctr <= r_ctr;
            endcase
            r_rd_vld <= w_issue;
            if (i_ctrl.dp_op == arpc_pkg::DP_TICK_INC) begin
                r_secs <= r_secs + arpc_pkg::TIME_W'(1);
            end
            r_done <= (i_ctrl.dp_op == arpc_pkg::DP_RESULT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ctr[AW-1:0];
        if (w_accept) begin
            r_op     <= arpc_pkg::t_op'(i_operation);
            r_ip     <= i_ip_address;
            r_mac    <= i_mac_address;
            r_hit    <= 1'b0;
            r_fmac   <= '0;
            r_stored <= 1'b0;
        end else begin
            if (w_match) begin
                r_hit  <= 1'b1;
                r_fmac <= w_rd.mac;
            end
            if (w_ins_wr) begin
                r_stored <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.clr_last  = (r_ctr == CW'(LAST));
        o_stat.scan_done = r_rd_vld && (r_rd_idx == AW'(LAST));
        o_stat.ins_found = w_ins_found;
        o_stat.op_lookup = (r_op == arpc_pkg::OP_LOOKUP);
        o_stat.op_insert = (r_op == arpc_pkg::OP_INSERT);
        o_stat.op_tick   = (r_op == arpc_pkg::OP_TICK);
    end

    assign o_done      = r_done;
    assign o_hit       = r_hit;
    assign o_found_mac = r_fmac;
    assign o_stored    = r_stored;

endmodule

>>> hdl/arp_cache_table_with_aging_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_table_with_aging_unit: ARP cache with aging
// Result strobe o_done follows a lookup or a tick once all N entries are
// scanned, an insert once free slot k is written (after a full scan when full),
// a no-op with no scan. One item at a time; the scan reads one entry a cycle.
// start is taken again in the cycle o_done is shown; results cannot stall.
// After reset a clearing pass over all N entries runs with busy high.
// ----------------------------------------------------------------------------
module arp_cache_table_with_aging_unit #(
    parameter int NUM_ENTRIES = arpc_pkg::NUM_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [arpc_pkg::OP_W-1:0]   i_operation,
    input  logic [arpc_pkg::IP_W-1:0]   i_ip_address,
    input  logic [arpc_pkg::MAC_W-1:0]  i_mac_address,
    output logic                        o_done,
    output logic                        o_hit,
    output logic [arpc_pkg::MAC_W-1:0]  o_found_mac,
    output logic                        o_stored,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arpc_pkg::APB_AW-1:0] paddr,
    input  logic [arpc_pkg::APB_DW-1:0] pwdata,
    output logic [arpc_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    arpc_pkg::t_ctrl             w_ctrl;
    arpc_pkg::t_stat             w_stat;
    logic [arpc_pkg::LIFE_W-1:0] r_lifetime;
    logic                        w_sel_life;

    assign pready     = 1'b1;
    assign w_sel_life = (paddr[arpc_pkg::APB_AW-1:2] == arpc_pkg::REG_LIFETIME);
    assign prdata     = w_sel_life ? arpc_pkg::APB_DW'(r_lifetime) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= arpc_pkg::LIFETIME_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_life) begin
            r_lifetime <= pwdata[arpc_pkg::LIFE_W-1:0];
        end
    end

    assign busy = !w_ctrl.idle;

    arpc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    arpc_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_start       (start),
        .i_operation   (i_operation),
        .i_ip_address  (i_ip_address),
        .i_mac_address (i_mac_address),
        .i_lifetime    (r_lifetime),
        .o_stat        (w_stat),
        .o_done        (o_done),
        .o_hit         (o_hit),
        .o_found_mac   (o_found_mac),
        .o_stored      (o_stored)
    );

endmodule

>>> hdl/arpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker: ARP cache port checks
// Timing and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module arpc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic                        o_hit,
    input logic [arpc_pkg::MAC_W-1:0]  o_found_mac,
    input logic                        o_stored
);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result beat right after accept");

    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_stored))
        else $error("hit and stored both set");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_found_mac == '0))
        else $error("found_mac nonzero on miss");

endmodule

bind arp_cache_table_with_aging_unit arpc_checker u_chk (.*);
